// ===== src/tli_pkg.sv =====
// Shared types and constants for the table linear interpolator.
`default_nettype none
package tli_pkg;

  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int ROW_W   = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int ADDR_W  = 3;
  localparam int APB_W   = 32;

  localparam logic [COUNT_W-1:0] ROW_COUNT_RESET = 5'd2;

  // register index decoded from paddr[ADDR_W-1:2]
  localparam logic REG_ROW_COUNT = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_FORWARD = 2'd1,
    CMD_INV_INC = 2'd2,
    CMD_INV_DEC = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_OUTSIDE    = 2'd1,
    STAT_ZERO_WIDTH = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_LOW,
    ST_HIGH,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== src/tli_ifs.sv =====
// Valid/ready channel interfaces for request and response words.
`default_nettype none
interface tli_req_if
  import tli_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ROW_W-1:0]  row_index;
  logic [DATA_W-1:0] x_value;
  logic [DATA_W-1:0] y_value;
  logic [DATA_W-1:0] query_value;

  modport source (output valid, command, row_index, x_value, y_value, query_value,
                  input ready);
  modport sink   (input valid, command, row_index, x_value, y_value, query_value,
                  output ready);
endinterface

interface tli_rsp_if
  import tli_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_value;
  logic [STAT_W-1:0] status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

// ===== src/tli_divider.sv =====
// Restoring divider, one quotient bit per cycle, 64 by 32 with 32-bit quotient.
`default_nettype none
module tli_divider
  import tli_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [2*DATA_W-1:0]   dividend,
  input  wire logic [DATA_W-1:0]     divisor,
  output logic                       done,
  output logic [DATA_W-1:0]          quotient
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvd;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  logic [DATA_W:0]   trial;
  logic              fits;
  logic [DATA_W-1:0] rem_next;

  // caller guarantees dividend[63:32] < divisor, so the quotient fits
  always_comb begin
    trial    = {rem, dvd[DATA_W-1]};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? DATA_W'(trial - {1'b0, divisor}) : trial[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= CNT_W'(DATA_W);
      end else if (busy) begin
        cnt  <= cnt - CNT_W'(1);
        busy <= (cnt != CNT_W'(1));
        done <= (cnt == CNT_W'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[2*DATA_W-1:DATA_W];
      dvd <= dividend[DATA_W-1:0];
    end else if (busy) begin
      rem      <= rem_next;
      dvd      <= {dvd[DATA_W-2:0], 1'b0};
      quotient <= {quotient[DATA_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== src/table_linear_interpolator.sv =====
// Table linear interpolator: breakpoint table, binary search and serial interpolation.
//
// Holds up to MAX_ROWS (x, y) rows of signed fixed point. A load word (command 0)
// writes one row and gives no response. A query word searches the
// first row_count rows (clamped to 2..MAX_ROWS) for the bracketing segment, on x for
// forward mode or on y (rising or falling) for the inverse modes, then returns
// (q-a0)*(b1-b0)/(a1-a0)+b0 truncated toward zero, with status ok, outside table
// (result zero) or zero-width segment (lower endpoint returned). The search makes C
// compared probes, where C runs from 1 to ceil(log2(row_count))+1; each compared
// probe is a registered table read and a compare. Two row reads follow. A miss or a
// zero-width segment goes straight to the response. An interpolation adds one 32x32
// multiply, a divider start, the one-bit-per-cycle divider (32 quotient bits and its
// done flag), an add and a post. The sequencer passes through idle before the next
// word is taken. The request side stays not-ready while a query is in flight; a
// finished response waits in an output register, so the next word is taken even
// while the response is not yet accepted.
// Table rows are undefined until loaded; no clearing pass runs after reset.
// row_count sits at APB byte address 0 and reads back.
`default_nettype none
module table_linear_interpolator
  import tli_pkg::*;
#(
  parameter int MAX_ROWS      = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [APB_W-1:0]  pwdata,
  output logic      [APB_W-1:0]  prdata,
  output logic                   pready,
  tli_req_if.sink                req,
  tli_rsp_if.source              rsp
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = AW + COUNT_W;
  // binary point position does not enter the arithmetic; kept for the data format
  localparam int INT_BITS = DATA_W - FRACTION_BITS;

  // ---------------- configuration ----------------
  logic [COUNT_W-1:0] row_count;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1:2] == REG_ROW_COUNT) && (INT_BITS > 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      row_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_W'(row_count) : '0;

  // last usable row index, row count clamped to 2..MAX_ROWS
  logic [CW-1:0] rc_ext;
  logic [AW-1:0] last_idx;

  always_comb begin
    rc_ext = CW'(row_count);
    if (rc_ext < CW'(2)) begin
      last_idx = AW'(1);
    end else if (rc_ext > CW'(MAX_ROWS)) begin
      last_idx = AW'(MAX_ROWS - 1);
    end else begin
      last_idx = AW'(rc_ext - CW'(1));
    end
  end

  // ---------------- table memory ----------------
  logic [DATA_W-1:0] x_mem [MAX_ROWS];
  logic [DATA_W-1:0] y_mem [MAX_ROWS];
  logic [DATA_W-1:0] rd_x;
  logic [DATA_W-1:0] rd_y;
  logic [AW-1:0]     raddr;
  logic              mem_we;
  logic [AW-1:0]     waddr;
  logic              row_ok;

  assign waddr  = AW'(req.row_index);
  assign row_ok = (CW'(req.row_index) < CW'(MAX_ROWS));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      x_mem[waddr] <= req.x_value;
      y_mem[waddr] <= req.y_value;
    end
    rd_x <= x_mem[raddr];
    rd_y <= y_mem[raddr];
  end

  // ---------------- sequencer ----------------
  state_t state, state_next;

  cmd_t                mode;
  logic signed [DATA_W-1:0] q;
  logic [AW-1:0]       lo, hi, mid;
  logic [AW:0]         lo_hi_sum;
  logic [AW-1:0]       probe;
  logic signed [DATA_W-1:0] key_rd, val_rd;
  logic                falling;
  logic                go_low;

  logic signed [DATA_W-1:0] k0, v0;
  logic                in_seg, flat;
  logic [DATA_W-1:0]   dq_mag, db_mag, da_mag;
  logic                neg;
  logic [2*DATA_W-1:0] prod;

  logic                div_start, div_done;
  logic [DATA_W-1:0]   quo;

  status_t             res_status;
  logic [DATA_W-1:0]   res_value;
  logic                out_valid;
  logic                out_load;

  function automatic logic [DATA_W-1:0] mag33(input logic [DATA_W:0] d);
    logic [DATA_W:0] n;
    begin
      n = d[DATA_W] ? (~d + 1'b1) : d;
      return n[DATA_W-1:0];
    end
  endfunction

  assign lo_hi_sum = {1'b0, lo} + {1'b0, hi};
  assign probe     = lo_hi_sum[AW:1];
  assign falling   = (mode == CMD_INV_DEC);
  assign key_rd    = (mode == CMD_FORWARD) ? rd_x : rd_y;
  assign val_rd    = (mode == CMD_FORWARD) ? rd_y : rd_x;
  assign go_low    = falling ? (q <= key_rd) : (q >= key_rd);
  assign out_load  = (state == ST_DONE) && (!out_valid || rsp.ready);

  // with k0 latched and row mid+1 on the read port
  always_comb begin
    if (falling) begin
      in_seg = (q <= k0) && (q >= key_rd);
    end else begin
      in_seg = (q >= k0) && (q <= key_rd);
    end
    flat = (k0 == key_rd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    raddr      = mid;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          unique case (cmd_t'(req.command)) inside
            CMD_LOAD: begin
              mem_we = row_ok;
            end
            CMD_FORWARD, CMD_INV_INC, CMD_INV_DEC: begin
              state_next = ST_SEARCH;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        raddr      = probe;
        state_next = (probe == mid) ? ST_LOW : ST_CMP;
      end
      ST_CMP:  state_next = ST_SEARCH;
      ST_LOW: begin
        raddr      = mid + AW'(1);
        state_next = ST_HIGH;
      end
      ST_HIGH: state_next = (!in_seg || flat) ? ST_DONE : ST_MUL;
      ST_MUL:  state_next = ST_LOAD;
      ST_LOAD: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV:  state_next = div_done ? ST_SUM : ST_DIV;
      ST_SUM:  state_next = ST_DONE;
      ST_DONE: state_next = out_load ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  logic [DATA_W:0]   dq_w, db_w, da_w;
  logic [DATA_W+1:0] delta, sum;

  always_comb begin
    dq_w  = {q[DATA_W-1], q} - {k0[DATA_W-1], k0};
    da_w  = {key_rd[DATA_W-1], key_rd} - {k0[DATA_W-1], k0};
    db_w  = {val_rd[DATA_W-1], val_rd} - {v0[DATA_W-1], v0};
    delta = neg ? (~{2'b00, quo} + 1'b1) : {2'b00, quo};
    sum   = {{2{v0[DATA_W-1]}}, v0} + delta;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        mode <= cmd_t'(req.command);
        q    <= req.query_value;
        lo   <= '0;
        hi   <= last_idx;
        mid  <= last_idx;
      end
      ST_SEARCH: begin
        mid <= probe;
      end
      ST_CMP: begin
        if (go_low) begin
          lo <= mid;
        end else begin
          hi <= mid;
        end
      end
      ST_LOW: begin
        k0 <= key_rd;
        v0 <= val_rd;
      end
      ST_HIGH: begin
        dq_mag <= mag33(dq_w);
        da_mag <= mag33(da_w);
        db_mag <= mag33(db_w);
        neg    <= dq_w[DATA_W] ^ da_w[DATA_W] ^ db_w[DATA_W];
        if (!in_seg) begin
          res_status <= STAT_OUTSIDE;
          res_value  <= '0;
        end else if (flat) begin
          res_status <= STAT_ZERO_WIDTH;
          res_value  <= v0;
        end else begin
          res_status <= STAT_OK;
        end
      end
      ST_MUL: begin
        prod <= dq_mag * db_mag;
      end
      ST_SUM: begin
        res_value <= sum[DATA_W-1:0];
      end
      default: begin
      end
    endcase
  end

  tli_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (da_mag),
    .done     (div_done),
    .quotient (quo)
  );

  // ---------------- response register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.result_value <= res_value;
      rsp.status       <= res_status;
    end
  end

  assign rsp.valid = out_valid;

`ifndef SYNTHESIS
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("response raised outside the done state");

  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOW) |-> (mid < last_idx))
    else $error("segment index beyond last row");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (lo <= hi))
    else $error("search bounds crossed");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");
`endif

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the table linear interpolator: lookup words, results and row_count.
`default_nettype none
module testbench;
  import tli_pkg::*;

  // Table depth of the instance (MAX_ROWS left at its default).
  localparam int TABLE_ROWS = 16;
  // Words to plan before the run winds down; loads and queries both count.
  localparam int WORD_TARGET = 900;
  // One receiver hold-off, long enough to fill the output register and stall requests.
  localparam int HOLD_CYCLES = 400;
  // Quiet cycles after the last result: loads in flight, output register, margin.
  localparam int SETTLE_CYCLES = 64;
  // Cycles with no handshake at all before the run is declared hung. The worst
  // honest gap is the hold-off plus one full query.
  localparam int STALL_LIMIT = 5000;
  localparam int IDLE_PERCENT = 28;

  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;

  // How the stimulus lays out the breakpoint table.
  typedef enum int {
    SHAPE_RISING,     // x rising, y rising
    SHAPE_FALLING,    // x rising, y falling
    SHAPE_SCATTERED   // x rising, y anywhere (forward lookups only make sense)
  } table_shape_t;

  typedef struct packed {
    cmd_t              command;
    logic [ROW_W-1:0]  row_index;
    logic [DATA_W-1:0] x_value;
    logic [DATA_W-1:0] y_value;
    logic [DATA_W-1:0] query_value;
  } lookup_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_t           status;
  } lookup_answer_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  tli_req_if req_ch ();
  tli_rsp_if rsp_ch ();

  table_linear_interpolator DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // Words waiting for the request handshake; the front one is on the bus.
  lookup_word_t   word_q [$];
  // Lookup answers owed by the block, oldest first.
  lookup_answer_t answer_q [$];

  // Predictor's own table, updated as load words are accepted, and row count, set by each APB write.
  logic signed [DATA_W-1:0] x_col [TABLE_ROWS];
  logic signed [DATA_W-1:0] y_col [TABLE_ROWS];
  logic [COUNT_W-1:0]       row_count_now;

  // What the stimulus has loaded so far, used to aim queries at real segments.
  longint plan_x [TABLE_ROWS];
  longint plan_y [TABLE_ROWS];
  int     rows_live;

  int   fault_count   = 0;
  int   words_planned = 0;
  int   hold_asked    = 0;
  int   hold_seen;
  int   hold_left;
  logic calm          = 1'b0;  // no idling on either side while set
  logic word_taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: binary search over the clamped row count, then exact
  // (q-a0)*(b1-b0)/(a1-a0)+b0 with the quotient truncated toward zero.
  // ---------------------------------------------------------------------------
  function automatic lookup_answer_t interpolate(input cmd_t cmd,
                                                 input logic [DATA_W-1:0] query);
    lookup_answer_t ans;
    longint q, k0, k1, v0, v1, dq, dk, dv, probe;
    bit [63:0] mdq, mdk, mdv, mag;
    bit falling, in_seg, neg;
    int n, lo, hi, mid;
    q       = longint'($signed(query));
    falling = (cmd == CMD_INV_DEC);
    n = (row_count_now < 2) ? 2 : (row_count_now > TABLE_ROWS) ? TABLE_ROWS : row_count_now;
    lo  = 0;
    hi  = n - 1;
    mid = n - 1;
    while (mid != (lo + hi) / 2) begin
      mid   = (lo + hi) / 2;
      probe = (cmd == CMD_FORWARD) ? x_col[mid] : y_col[mid];
      if (falling ? (q <= probe) : (q >= probe)) lo = mid;
      else hi = mid;
    end
    if (cmd == CMD_FORWARD) begin
      k0 = x_col[mid];  k1 = x_col[mid+1];
      v0 = y_col[mid];  v1 = y_col[mid+1];
    end else begin
      k0 = y_col[mid];  k1 = y_col[mid+1];
      v0 = x_col[mid];  v1 = x_col[mid+1];
    end
    in_seg = falling ? (q <= k0 && q >= k1) : (q >= k0 && q <= k1);
    if (!in_seg) begin
      ans.value  = '0;
      ans.status = STAT_OUTSIDE;
    end else if (k0 == k1) begin
      // zero-width segment: lower row's output column
      ans.value  = DATA_W'(v0);
      ans.status = STAT_ZERO_WIDTH;
    end else begin
      dq  = q - k0;
      dk  = k1 - k0;
      dv  = v1 - v0;
      neg = ((dq < 0) != (dv < 0)) != (dk < 0);
      mdq = (dq < 0) ? -dq : dq;
      mdk = (dk < 0) ? -dk : dk;
      mdv = (dv < 0) ? -dv : dv;
      mag = (mdq * mdv) / mdk;  // < 2^64, fits unsigned
      v0  = v0 + (neg ? -longint'(mag) : longint'(mag));
      ans.value  = DATA_W'(v0);
      ans.status = STAT_OK;
    end
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: acceptance at the rising edge, new word at the falling edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        if (cmd_t'(req_ch.command) == CMD_LOAD) begin
          x_col[req_ch.row_index] = req_ch.x_value;
          y_col[req_ch.row_index] = req_ch.y_value;
        end else begin
          answer_q.push_back(interpolate(cmd_t'(req_ch.command), req_ch.query_value));
        end
        void'(word_q.pop_front());
      end
    end
  end

  // valid only drops after a handshake; an offered word stays put until taken
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || word_taken) begin
      if (word_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        req_ch.valid       <= 1'b1;
        req_ch.command     <= word_q[0].command;
        req_ch.row_index   <= word_q[0].row_index;
        req_ch.x_value     <= word_q[0].x_value;
        req_ch.y_value     <= word_q[0].y_value;
        req_ch.query_value <= word_q[0].query_value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response side: random stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_seen != hold_asked) begin
      hold_seen    <= hold_asked;
      hold_left    <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (answer_q.size() == 0) begin
        $error("unexpected result word: result_value %h status %0d",
               rsp_ch.result_value, rsp_ch.status);
        fault_count++;
      end else begin
        if (rsp_ch.result_value !== answer_q[0].value) begin
          $error("result_value: expected %h, actual %h",
                 answer_q[0].value, rsp_ch.result_value);
          fault_count++;
        end
        if (rsp_ch.status !== answer_q[0].status) begin
          $error("status: expected %0d, actual %0d", answer_q[0].status, rsp_ch.status);
          fault_count++;
        end
        void'(answer_q.pop_front());
      end
    end
  end

  // Hang detector: any handshake or register access restarts the count.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_word(input cmd_t cmd, input logic [ROW_W-1:0] row,
                                    input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                                    input logic [DATA_W-1:0] q);
    lookup_word_t w;
    w.command     = cmd;
    w.row_index   = row;
    w.x_value     = x;
    w.y_value     = y;
    w.query_value = q;
    word_q.push_back(w);
    words_planned++;
  endfunction

  function automatic longint saturate(input longint v);
    if (v > longint'(Q_MAX)) return longint'(Q_MAX);
    if (v < longint'(Q_MIN)) return longint'(Q_MIN);
    return v;
  endfunction

  // gap between neighboring keys; zero now and then for zero-width segments
  function automatic longint key_stride(input int scale);
    if ($urandom_range(0, 7) == 0) return 0;
    return longint'($urandom_range(1, 1 << scale));
  endfunction

  // Full table, x never falling; y per shape. Saturation piles rows up at the
  // ends of the range, which gives more zero-width segments.
  task automatic load_table(input table_shape_t shape);
    longint xv, yv;
    int     xs, ys;
    xs = $urandom_range(0, 28);
    ys = $urandom_range(0, 28);
    xv = longint'($signed($urandom));
    yv = longint'($signed($urandom));
    for (int r = 0; r < TABLE_ROWS; r++) begin
      plan_x[r] = xv;
      plan_y[r] = (shape == SHAPE_SCATTERED) ? longint'($signed($urandom)) : yv;
      push_word(CMD_LOAD, ROW_W'(r), DATA_W'(plan_x[r]), DATA_W'(plan_y[r]), $urandom);
      xv = saturate(xv + key_stride(xs));
      yv = saturate((shape == SHAPE_FALLING) ? yv - key_stride(ys) : yv + key_stride(ys));
    end
  endtask

  // Mostly the lookup that suits the table, aimed inside a live segment.
  task automatic push_query(input table_shape_t shape);
    cmd_t   cmd;
    longint lo_key, hi_key, span, q;
    int     seg, pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      cmd = CMD_FORWARD;
    else if (pick < 85)
      cmd = (shape == SHAPE_RISING)  ? CMD_INV_INC :
            (shape == SHAPE_FALLING) ? CMD_INV_DEC : cmd_t'($urandom_range(2, 3));
    else
      cmd = cmd_t'($urandom_range(1, 3));
    seg    = $urandom_range(0, rows_live - 2);
    lo_key = (cmd == CMD_FORWARD) ? plan_x[seg]   : plan_y[seg];
    hi_key = (cmd == CMD_FORWARD) ? plan_x[seg+1] : plan_y[seg+1];
    if (lo_key > hi_key) begin
      span   = lo_key;
      lo_key = hi_key;
      hi_key = span;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      span = hi_key - lo_key;
      q    = lo_key + longint'({$urandom, $urandom} % (span + 1));
    end else if (pick < 75) begin
      q = $urandom_range(0, 1) ? lo_key : hi_key;
    end else if (pick < 85) begin
      q = $urandom_range(0, 1) ? longint'(Q_MIN) : longint'(Q_MAX);
    end else begin
      q = longint'($signed($urandom));
    end
    push_word(cmd, ROW_W'($urandom), $urandom, $urandom, DATA_W'(q));
  endtask

  // Sender pause: everything taken, every answer back, loads given time to land.
  task automatic wait_until_idle();
    while (word_q.size() != 0 || req_ch.valid || answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of row_count, then a read back. Upper data bits are random noise.
  task automatic write_row_count(input logic [COUNT_W-1:0] count);
    logic [APB_W-1:0] data;
    data                = $urandom;
    data[COUNT_W-1:0]   = count;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ROW_COUNT, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    row_count_now = count;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COUNT_W-1:0] !== count) begin
      $error("row_count read back: expected %0d, actual %0d", count, prdata[COUNT_W-1:0]);
      fault_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    table_shape_t       shape;
    logic [COUNT_W-1:0] count;
    int                 phase, queries;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_ch.valid       = 1'b0;
    req_ch.command     = CMD_LOAD;
    req_ch.row_index   = '0;
    req_ch.x_value     = '0;
    req_ch.y_value     = '0;
    req_ch.query_value = '0;
    rsp_ch.ready       = 1'b0;
    row_count_now      = ROW_COUNT_RESET;
    shape              = SHAPE_RISING;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, at the reset row count of two: only rows 0 and 1 get read.
    // Full-range segment, both extremes of both columns.
    push_word(CMD_LOAD,    4'd0, Q_MIN, Q_MAX, '0);
    push_word(CMD_LOAD,    4'd1, Q_MAX, Q_MIN, '0);
    push_word(CMD_FORWARD, '0, '0, '0, Q_MIN);
    push_word(CMD_FORWARD, '0, '0, '0, Q_MAX);
    push_word(CMD_FORWARD, '0, '0, '0, 32'h0000_0000);
    push_word(CMD_FORWARD, '0, '0, '0, 32'hffff_ffff);
    push_word(CMD_INV_DEC, '0, '0, '0, Q_MAX);
    push_word(CMD_INV_DEC, '0, '0, '0, Q_MIN);
    push_word(CMD_INV_DEC, '0, '0, '0, 32'h1234_5678);
    push_word(CMD_INV_INC, '0, '0, '0, 32'h0000_0000);  // wrong direction: outside
    // Both rows equal: zero-width hits and a miss beside them.
    push_word(CMD_LOAD,    4'd1, Q_MIN, Q_MAX, '0);
    push_word(CMD_FORWARD, '0, '0, '0, Q_MIN);
    push_word(CMD_FORWARD, '0, '0, '0, 32'h0000_0000);
    push_word(CMD_INV_INC, '0, '0, '0, Q_MAX);
    push_word(CMD_INV_DEC, '0, '0, '0, Q_MAX);
    // Small falling segment: truncation toward zero and both outside edges.
    push_word(CMD_LOAD,    4'd0, 32'h0000_0000, 32'h0000_0000, '0);
    push_word(CMD_LOAD,    4'd1, 32'h0001_0000, 32'hfffd_0000, '0);
    push_word(CMD_FORWARD, '0, '0, '0, 32'h0000_8000);
    push_word(CMD_FORWARD, '0, '0, '0, 32'hffff_ffff);
    push_word(CMD_FORWARD, '0, '0, '0, 32'h0001_0001);
    push_word(CMD_INV_DEC, '0, '0, '0, 32'hffff_0000);
    push_word(CMD_INV_INC, '0, '0, '0, 32'hffff_0000);

    // Random phases. Each starts from idle with a new row_count; the first few
    // sweep the clamp edges, then any 5-bit value.
    phase = 0;
    while (words_planned < WORD_TARGET) begin
      wait_until_idle();
      case (phase)
        0:       count = 5'd16;
        1:       count = 5'd0;
        2:       count = 5'd31;
        3:       count = 5'd1;
        4:       count = 5'd17;
        5:       count = 5'd2;
        default: count = COUNT_W'($urandom_range(0, 31));
      endcase
      write_row_count(count);
      rows_live = (count < 2) ? 2 : (count > TABLE_ROWS) ? TABLE_ROWS : count;
      calm = (phase == 6);
      if (phase == 3) hold_asked++;  // long receiver hold-off while words keep coming

      // The first phase reads all rows, so it must load them all. Later a few
      // phases just overwrite some rows with junk, breaking the ordering.
      if (phase > 0 && $urandom_range(0, 99) < 20) begin
        repeat ($urandom_range(1, 4)) begin
          int r;
          r         = $urandom_range(0, TABLE_ROWS - 1);
          plan_x[r] = longint'($signed($urandom));
          plan_y[r] = longint'($signed($urandom));
          push_word(CMD_LOAD, ROW_W'(r), DATA_W'(plan_x[r]), DATA_W'(plan_y[r]), $urandom);
        end
      end else begin
        shape = table_shape_t'($urandom_range(0, 2));
        load_table(shape);
      end

      queries = $urandom_range(20, 60);
      repeat (queries) push_query(shape);
      phase++;
    end

    wait_until_idle();
    if (fault_count == 0 && answer_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
